// ===== design/mhd_pkg.sv =====
package mhd_pkg;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_ID3V2   = 2'd2,
		KIND_ID3V1   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		VER_NONE  = 2'd0,
		VER_MPEG1 = 2'd1,
		VER_MPEG2 = 2'd2
	} mpeg_ver_t;

	localparam logic [31:0] FRAME_MASK  = 32'hFFFE0000;
	localparam logic [31:0] FRAME_MPEG1 = 32'hFFFA0000;
	localparam logic [31:0] FRAME_MPEG2 = 32'hFFF20000;
	localparam logic [31:0] ID3_MASK    = 32'hFFFFFF00;
	localparam logic [31:0] ID3V1_SIG   = 32'h54414700;
	localparam logic [31:0] ID3V2_SIG   = 32'h49443300;
	localparam logic [31:0] SYNC_BITS   = 32'h80808080;
	localparam logic [28:0] ID3V2_HDR   = 29'd10;

	localparam logic [1:0] SIDX_RESERVED = 2'd3;
	localparam logic [3:0] BIDX_BAD      = 4'd15;

	// Classified item handed from the front to the back.
	typedef struct packed {
		kind_t       kind;
		logic        mpeg2;
		logic [1:0]  sidx;
		logic [3:0]  bidx;
		logic        pad;
		logic        sync_ok;
		logic [27:0] size;
	} mhd_rec_t;

	localparam logic [15:0] RATE_TAB [0:1][0:3] = '{
		'{16'd44100, 16'd48000, 16'd32000, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0}
	};

	localparam logic [8:0] KBPS_TAB [0:1][0:15] = '{
		'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
	};

	// Frame length without padding, floor(coef * kbps / rate), by version,
	// rate index and bitrate index. Free format, bad bitrate and reserved
	// rate entries are zero.
	localparam logic [10:0] LEN_TAB [0:1][0:3][0:15] = '{
		'{
			'{11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
			  11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0},
			'{11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
			  11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0},
			'{11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
			  11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0},
			'{16{11'd0}}
		},
		'{
			'{11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
			  11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0},
			'{11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
			  11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0},
			'{11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
			  11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0},
			'{16{11'd0}}
		}
	};

endpackage

// ===== design/mhd_if.sv =====
interface mhd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;
	logic [31:0] size_word;

	modport source (output valid, output header_word, output size_word, input ready);
	modport sink (input valid, input header_word, input size_word, output ready);
endinterface

interface mhd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  mpeg_version;
	logic [15:0] sample_rate_hz;
	logic [8:0]  bitrate_kbps;
	logic        padding;
	logic [10:0] frame_bytes;
	logic [28:0] tag_bytes;
	logic        error;

	modport source (
		output valid, output kind, output mpeg_version, output sample_rate_hz,
		output bitrate_kbps, output padding, output frame_bytes, output tag_bytes,
		output error, input ready
	);
	modport sink (
		input valid, input kind, input mpeg_version, input sample_rate_hz,
		input bitrate_kbps, input padding, input frame_bytes, input tag_bytes,
		input error, output ready
	);
endinterface

// ===== design/mhd_front.sv =====
module mhd_front
	import mhd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [31:0] header_word,
	input  logic [31:0] size_word,
	output logic     rec_valid,
	input  logic     rec_ready,
	output mhd_rec_t rec
);

	mhd_rec_t rec_c;
	mhd_rec_t rec_s1;
	logic     vld_s1;

	always_comb begin
		rec_c = '0;
		rec_c.kind = KIND_UNKNOWN;
		if ((header_word & FRAME_MASK) == FRAME_MPEG1 ||
		    (header_word & FRAME_MASK) == FRAME_MPEG2) begin
			rec_c.kind  = KIND_FRAME;
			rec_c.mpeg2 = ((header_word & FRAME_MASK) == FRAME_MPEG2);
			rec_c.sidx  = header_word[11:10];
			rec_c.bidx  = header_word[15:12];
			rec_c.pad   = header_word[9];
		end else if ((header_word & ID3_MASK) == ID3V2_SIG) begin
			rec_c.kind    = KIND_ID3V2;
			rec_c.sync_ok = ((size_word & SYNC_BITS) == 32'd0);
			rec_c.size    = {size_word[30:24], size_word[22:16],
			                 size_word[14:8], size_word[6:0]};
		end else if ((header_word & ID3_MASK) == ID3V1_SIG) begin
			rec_c.kind = KIND_ID3V1;
		end
	end

	assign in_ready  = !vld_s1 || rec_ready;
	assign rec_valid = vld_s1;
	assign rec       = rec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (rec_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rec_s1 <= rec_c;
		end
	end

endmodule

// ===== design/mhd_queue.sv =====
module mhd_queue
	import mhd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  mhd_rec_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output mhd_rec_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	mhd_rec_t      mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/mhd_back.sv =====
module mhd_back
	import mhd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	output logic        rec_ready,
	input  mhd_rec_t    rec,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [1:0]  mpeg_version,
	output logic [15:0] sample_rate_hz,
	output logic [8:0]  bitrate_kbps,
	output logic        padding,
	output logic [10:0] frame_bytes,
	output logic [28:0] tag_bytes,
	output logic        error
);

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [1:0]  ver_q;
	logic [15:0] rate_q;
	logic [8:0]  kbps_q;
	logic        pad_q;
	logic [10:0] len_q;
	logic [28:0] tag_q;
	logic        err_q;

	logic [1:0]  ver_c;
	logic [15:0] rate_c;
	logic [8:0]  kbps_c;
	logic        pad_c;
	logic [10:0] len_c;
	logic [10:0] base_len;
	logic [28:0] tag_c;
	logic        err_c;

	assign base_len = LEN_TAB[rec.mpeg2][rec.sidx][rec.bidx];

	always_comb begin
		ver_c  = VER_NONE;
		rate_c = '0;
		kbps_c = '0;
		pad_c  = 1'b0;
		len_c  = '0;
		tag_c  = '0;
		err_c  = 1'b0;
		case (rec.kind)
			KIND_FRAME: begin
				ver_c  = rec.mpeg2 ? VER_MPEG2 : VER_MPEG1;
				rate_c = RATE_TAB[rec.mpeg2][rec.sidx];
				kbps_c = KBPS_TAB[rec.mpeg2][rec.bidx];
				pad_c  = rec.pad;
				err_c  = (rec.sidx == SIDX_RESERVED) || (rec.bidx == BIDX_BAD);
				len_c  = (base_len == '0) ? '0 : base_len + {10'd0, rec.pad};
			end
			KIND_ID3V2: begin
				err_c = !rec.sync_ok;
				tag_c = rec.sync_ok ? {1'b0, rec.size} + ID3V2_HDR : '0;
			end
			default: begin
				ver_c = VER_NONE;
			end
		endcase
	end

	assign rec_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_valid && rec_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && rec_ready) begin
			kind_q <= rec.kind;
			ver_q  <= ver_c;
			rate_q <= rate_c;
			kbps_q <= kbps_c;
			pad_q  <= pad_c;
			len_q  <= len_c;
			tag_q  <= tag_c;
			err_q  <= err_c;
		end
	end

	assign out_valid      = valid_q;
	assign kind           = kind_q;
	assign mpeg_version   = ver_q;
	assign sample_rate_hz = rate_q;
	assign bitrate_kbps   = kbps_q;
	assign padding        = pad_q;
	assign frame_bytes    = len_q;
	assign tag_bytes      = tag_q;
	assign error          = err_q;

endmodule

// ===== design/mp3_header_decoder_unit.sv =====
// Channel | Dir | Fields
// req     | in  | header_word[31:0], size_word[31:0]
// rsp     | out | kind, mpeg_version, sample_rate_hz, bitrate_kbps, padding,
//         |     | frame_bytes, tag_bytes, error
//
// One item per cycle is sustained while rsp is ready; each item yields exactly one result item.
// An accepted item passes the front register, the queue and the output register in turn.
// The front stage, the QUEUE_DEPTH entry queue and the output register each stall
// on their own, so req stays ready while a result waits as long as room remains.
// Frame lengths come from a constant table indexed by version, rate and bitrate.
// Reset clears only the valid flags, the queue pointers and the queue count.
module mp3_header_decoder_unit
	import mhd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	mhd_in_if.sink    req,
	mhd_out_if.source rsp
);

	mhd_rec_t front_rec;
	mhd_rec_t back_rec;
	logic     front_valid;
	logic     front_ready;
	logic     back_valid;
	logic     back_ready;

	mhd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.header_word(req.header_word),
		.size_word  (req.size_word),
		.rec_valid  (front_valid),
		.rec_ready  (front_ready),
		.rec        (front_rec)
	);

	mhd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_data (front_rec),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.pop_data  (back_rec)
	);

	mhd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (back_valid),
		.rec_ready     (back_ready),
		.rec           (back_rec),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.kind          (rsp.kind),
		.mpeg_version  (rsp.mpeg_version),
		.sample_rate_hz(rsp.sample_rate_hz),
		.bitrate_kbps  (rsp.bitrate_kbps),
		.padding       (rsp.padding),
		.frame_bytes   (rsp.frame_bytes),
		.tag_bytes     (rsp.tag_bytes),
		.error         (rsp.error)
	);

endmodule

// ===== design/mhd_checker.sv =====
module mhd_checker
	import mhd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  kind,
	input logic [1:0]  mpeg_version,
	input logic [15:0] sample_rate_hz,
	input logic [8:0]  bitrate_kbps,
	input logic        padding,
	input logic [10:0] frame_bytes,
	input logic [28:0] tag_bytes,
	input logic        error
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(frame_bytes)
		&& $stable(tag_bytes) && $stable(error))
		else $error("result item changed while stalled");

	a_frame_version: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_FRAME |-> mpeg_version != VER_NONE && tag_bytes == '0)
		else $error("frame result without version or with tag length");

	a_nonframe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind != KIND_FRAME |-> mpeg_version == VER_NONE
		&& sample_rate_hz == '0 && bitrate_kbps == '0 && padding == 1'b0
		&& frame_bytes == '0)
		else $error("frame fields set on a non-frame result");

	a_error_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error |-> frame_bytes == '0 && tag_bytes == '0)
		else $error("length reported together with error");

	a_id3v1_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (kind == KIND_ID3V1 || kind == KIND_UNKNOWN) |->
		tag_bytes == '0 && !error)
		else $error("tag or unknown result carries tag length or error");

endmodule

bind mp3_header_decoder_unit mhd_checker u_mhd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.kind          (rsp.kind),
	.mpeg_version  (rsp.mpeg_version),
	.sample_rate_hz(rsp.sample_rate_hz),
	.bitrate_kbps  (rsp.bitrate_kbps),
	.padding       (rsp.padding),
	.frame_bytes   (rsp.frame_bytes),
	.tag_bytes     (rsp.tag_bytes),
	.error         (rsp.error)
);

// ===== bench/tb_mp3_header_decoder_unit.sv =====
module tb_mp3_header_decoder_unit
	import mhd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned ITEMS_PER_PHASE = 300;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 8;

	localparam int unsigned PHASE_IDLE [5] = '{0, 81, 0, 25, 0};
	localparam int unsigned PHASE_STALL [5] = '{0, 0, 81, 25, 0};

	localparam int unsigned MPEG1_KBPS [16] = '{
		0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0
	};
	localparam int unsigned MPEG2_KBPS [16] = '{
		0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0
	};

	localparam logic [63:0] DIRECTED [25] = '{
		{32'h00000000, 32'h00000000},
		{32'hFFFFFFFF, 32'hFFFFFFFF},
		{FRAME_MPEG1 | 32'h0001EAFF, 32'hFFFFFFFF},
		{FRAME_MPEG1 | 32'h00001000, 32'h00000000},
		{FRAME_MPEG1 | 32'h00000400, 32'h00000000},
		{FRAME_MPEG1 | 32'h0000F000, 32'h00000000},
		{FRAME_MPEG1 | 32'h00005C00, 32'h00000000},
		{FRAME_MPEG1 | 32'h0000FE00, 32'h00000000},
		{FRAME_MPEG2 | 32'h0001EA00, 32'h12345678},
		{FRAME_MPEG2 | 32'h00001200, 32'h00000000},
		{FRAME_MPEG2 | 32'h00000800, 32'h00000000},
		{FRAME_MPEG2 | 32'h0000F400, 32'h00000000},
		{FRAME_MPEG2 | 32'h00009C00, 32'h00000000},
		{FRAME_MPEG2 | 32'h000176A5, 32'h00000000},
		{ID3V2_SIG | 32'h00000004, 32'h7F7F7F7F},
		{ID3V2_SIG | 32'h000000FF, 32'h00000000},
		{ID3V2_SIG, 32'h00000080},
		{ID3V2_SIG | 32'h00000003, SYNC_BITS},
		{ID3V2_SIG, 32'h80000000},
		{ID3V1_SIG | 32'h000000FF, 32'hFFFFFFFF},
		{ID3V1_SIG, 32'h00000000},
		{32'hFFFC0000, 32'h00000000},
		{32'h49443200, 32'h0000007F},
		{32'hFFF0E400, 32'h00000000},
		{32'h54414800, 32'h00000000}
	};

	typedef struct packed {
		kind_t       kind;
		mpeg_ver_t   ver;
		logic [15:0] rate;
		logic [8:0]  kbps;
		logic        pad;
		logic [10:0] frame_len;
		logic [28:0] tag_len;
		logic        err;
	} hdr_result_t;

	class header_scoreboard;
		hdr_result_t pending_decodes[$];
		int unsigned fails = 0;

		function automatic hdr_result_t decode_header(logic [31:0] hw, logic [31:0] sw);
			hdr_result_t r;
			logic mpeg2;
			logic [1:0] sidx;
			logic [3:0] bidx;
			int unsigned rate;
			int unsigned kbps;
			int unsigned coef;
			r = '0;
			if ((hw & FRAME_MASK) == FRAME_MPEG1 || (hw & FRAME_MASK) == FRAME_MPEG2) begin
				mpeg2 = ((hw & FRAME_MASK) == FRAME_MPEG2);
				sidx = hw[11:10];
				bidx = hw[15:12];
				case (sidx)
					2'd0: rate = 44100;
					2'd1: rate = 48000;
					2'd2: rate = 32000;
					default: rate = 0;
				endcase
				if (mpeg2) begin
					rate = rate / 2;
				end
				kbps = mpeg2 ? MPEG2_KBPS[bidx] : MPEG1_KBPS[bidx];
				coef = mpeg2 ? 72000 : 144000;
				r.kind = KIND_FRAME;
				r.ver = mpeg2 ? VER_MPEG2 : VER_MPEG1;
				r.rate = 16'(rate);
				r.kbps = 9'(kbps);
				r.pad = hw[9];
				r.err = (sidx == SIDX_RESERVED) || (bidx == BIDX_BAD);
				if (!r.err && kbps != 0 && rate != 0) begin
					r.frame_len = 11'((coef * kbps) / rate + hw[9]);
				end
			end else if ((hw & ID3_MASK) == ID3V2_SIG) begin
				r.kind = KIND_ID3V2;
				if ((sw & SYNC_BITS) != 0) begin
					r.err = 1'b1;
				end else begin
					r.tag_len = {1'b0, sw[30:24], sw[22:16], sw[14:8], sw[6:0]} + ID3V2_HDR;
				end
			end else if ((hw & ID3_MASK) == ID3V1_SIG) begin
				r.kind = KIND_ID3V1;
			end
			return r;
		endfunction

		function void note_header(logic [31:0] hw, logic [31:0] sw);
			pending_decodes.push_back(decode_header(hw, sw));
		endfunction

		function void check_result(hdr_result_t got);
			hdr_result_t want;
			if (pending_decodes.size() == 0) begin
				$error("Result item arrived with no header outstanding.");
				fails++;
				return;
			end
			want = pending_decodes.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				fails++;
			end
			if (got.ver !== want.ver) begin
				$error("mpeg_version: expected %0d, actual %0d", want.ver, got.ver);
				fails++;
			end
			if (got.rate !== want.rate) begin
				$error("sample_rate_hz: expected %0d, actual %0d", want.rate, got.rate);
				fails++;
			end
			if (got.kbps !== want.kbps) begin
				$error("bitrate_kbps: expected %0d, actual %0d", want.kbps, got.kbps);
				fails++;
			end
			if (got.pad !== want.pad) begin
				$error("padding: expected %0d, actual %0d", want.pad, got.pad);
				fails++;
			end
			if (got.frame_len !== want.frame_len) begin
				$error("frame_bytes: expected %0d, actual %0d", want.frame_len, got.frame_len);
				fails++;
			end
			if (got.tag_len !== want.tag_len) begin
				$error("tag_bytes: expected %0d, actual %0d", want.tag_len, got.tag_len);
				fails++;
			end
			if (got.err !== want.err) begin
				$error("error: expected %0d, actual %0d", want.err, got.err);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mhd_in_if req_if();
	mhd_out_if rsp_if();

	mp3_header_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	header_scoreboard sb = new();

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver holds off for a whole stretch when asked, otherwise stalls at random.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		hdr_result_t got;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				sb.note_header(req_if.header_word, req_if.size_word);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got.kind = kind_t'(rsp_if.kind);
				got.ver = mpeg_ver_t'(rsp_if.mpeg_version);
				got.rate = rsp_if.sample_rate_hz;
				got.kbps = rsp_if.bitrate_kbps;
				got.pad = rsp_if.padding;
				got.frame_len = rsp_if.frame_bytes;
				got.tag_len = rsp_if.tag_bytes;
				got.err = rsp_if.error;
				sb.check_result(got);
			end
		end
	end

	task automatic send_header(input logic [31:0] hw, input logic [31:0] sw);
		int unsigned gap = 0;
		while ($urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.header_word <= hw;
		req_if.size_word <= sw;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
	endtask

	initial begin
		logic [31:0] hw;
		logic [31:0] sw;
		int unsigned pick;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.header_word <= '0;
		req_if.size_word <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			send_header(DIRECTED[i][63:32], DIRECTED[i][31:0]);
		end

		for (int p = 0; p < 5; p++) begin
			idle_pct = PHASE_IDLE[p];
			stall_pct = PHASE_STALL[p];
			if (p == 4) begin
				hold_request = HOLD_OFF_CYCLES;
			end
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				hw = $urandom;
				sw = $urandom;
				if (pick < 35) begin
					hw = FRAME_MPEG1 | (hw & 32'h0001FFFF);
				end else if (pick < 60) begin
					hw = FRAME_MPEG2 | (hw & 32'h0001FFFF);
				end else if (pick < 75) begin
					hw = ID3V2_SIG | (hw & 32'h000000FF);
					if ($urandom_range(3) != 0) begin
						sw = sw & ~SYNC_BITS;
					end
				end else if (pick < 85) begin
					hw = ID3V1_SIG | (hw & 32'h000000FF);
				end
				send_header(hw, sw);
			end
		end

		req_if.valid <= 1'b0;
		stall_pct = 0;
		@(posedge clk);
		while (sb.pending_decodes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/mhd_pkg.sv
design/mhd_if.sv
design/mhd_front.sv
design/mhd_queue.sv
design/mhd_back.sv
design/mp3_header_decoder_unit.sv
design/mhd_checker.sv
bench/tb_mp3_header_decoder_unit.sv
